/* rtl/env_sensor_compensation_defines.svh */
// Assertion macros shared by the compensation block.
`ifndef ENV_SENSOR_COMPENSATION_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ESC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("esc assertion failed");
`define ESC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("esc assertion failed");
`else
`define ESC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ESC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/esc_pkg.sv */
`default_nettype none
package esc_pkg;

   typedef enum logic [2:0] {
      REG_TEMP    = 3'd0,
      REG_PRESS_A = 3'd1,
      REG_PRESS_B = 3'd2,
      REG_PRESS_C = 3'd3,
      REG_HUM_A   = 3'd4,
      REG_HUM_B   = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [47:0] temp;
      logic [47:0] press_a;
      logic [47:0] press_b;
      logic [47:0] press_c;
      logic [39:0] hum_a;
      logic [31:0] hum_b;
   } calib_type;

   // one request after the front stages: divide still pending
   typedef struct packed {
      logic [31:0] fine_t;
      logic [31:0] temp_c;
      logic [16:0] hum;
      logic [63:0] num;
      logic [31:0] dvs;
   } item_type;

endpackage
`default_nettype wire

/* rtl/esc_front.sv */
`default_nettype none
module esc_front (
   input  logic               clock,
   input  logic               reset,
   input  esc_pkg::calib_type calib,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [19:0]        raw_temperature,
   input  logic [19:0]        raw_pressure,
   input  logic [15:0]        raw_humidity,
   input  logic               q_full,
   output logic               q_push,
   output esc_pkg::item_type  q_item
);
   import esc_pkg::*;

   localparam int unsigned NSTG = 13;

   logic [NSTG:1] v_ff;
   logic          en;

   logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
   logic signed [15:0] p2, p3, p4, p5, p6;
   logic signed [63:0] p1;

   assign t1 = $signed({16'b0, calib.temp[15:0]});
   assign t2 = 32'($signed(calib.temp[31:16]));
   assign t3 = 32'($signed(calib.temp[47:32]));
   assign p1 = $signed({48'b0, calib.press_a[15:0]});
   assign p2 = $signed(calib.press_a[31:16]);
   assign p3 = $signed(calib.press_a[47:32]);
   assign p4 = $signed(calib.press_b[15:0]);
   assign p5 = $signed(calib.press_b[31:16]);
   assign p6 = $signed(calib.press_b[47:32]);
   assign h1 = $signed({24'b0, calib.hum_a[7:0]});
   assign h2 = 32'($signed(calib.hum_a[23:8]));
   assign h3 = $signed({24'b0, calib.hum_a[31:24]});
   assign h6 = 32'($signed(calib.hum_a[39:32]));
   assign h4 = 32'($signed(calib.hum_b[15:0]));
   assign h5 = 32'($signed(calib.hum_b[31:16]));

   logic [19:0]        rp_ff [1:8];
   logic [15:0]        rh_ff [1:5];
   logic signed [31:0] ta_ff, td_ff, am_ff, dd_ff, a1_ff, d3_ff;
   logic signed [31:0] tf_ff [4:NSTG];
   logic signed [31:0] tc_ff [6:NSTG];
   logic signed [31:0] tcm_ff, hx6_ff, hx3_ff, h5x_ff;
   logic signed [32:0] v1_ff;
   logic [63:0]        v1sq_ff;
   logic signed [63:0] v1p5_ff [6:7];
   logic signed [63:0] v1p2_ff [6:7];
   logic signed [31:0] lhsp_ff, ha_ff, hb_ff;
   logic signed [63:0] v2a_ff, v1a_ff, v2_ff, v1b_ff, v1c_ff;
   logic signed [31:0] lhs_ff [7:10];
   logic signed [31:0] inm_ff, inner_ff, rhsm_ff, rhs_ff;
   logic [63:0]        num_ff [9:NSTG];
   logic [31:0]        dvs_ff [10:NSTG];
   logic signed [31:0] hx_ff [11:NSTG];
   logic signed [31:0] qq_ff, hs_ff;

   logic signed [31:0] rt32, rh32, xw, qw, hf;
   logic [31:0]        va;
   logic [20:0]        pr;
   logic signed [63:0] dvw;

   assign rt32 = $signed({12'b0, raw_temperature});
   assign rh32 = $signed({16'b0, rh_ff[5]});
   assign xw   = tf_ff[4] - 32'sd76800;
   assign va   = v1_ff[32] ? 32'(-v1_ff) : v1_ff[31:0];
   assign pr   = 21'h100000 - {1'b0, rp_ff[8]};
   assign dvw  = v1c_ff >>> 33;
   assign qw   = hx_ff[11] >>> 15;
   assign hf   = hx_ff[NSTG] - (hs_ff >>> 4);

   assign en       = !(v_ff[NSTG] && q_full);
   assign in_ready = en;
   assign q_push   = v_ff[NSTG] && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NSTG-1:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rp_ff[1] <= raw_pressure;
         rh_ff[1] <= raw_humidity;
         for (int i = 2; i <= 8; i++) rp_ff[i] <= rp_ff[i-1];
         for (int i = 2; i <= 5; i++) rh_ff[i] <= rh_ff[i-1];
         for (int i = 5; i <= NSTG; i++) tf_ff[i] <= tf_ff[i-1];
         for (int i = 7; i <= NSTG; i++) tc_ff[i] <= tc_ff[i-1];
         for (int i = 10; i <= NSTG; i++) num_ff[i] <= num_ff[i-1];
         for (int i = 11; i <= NSTG; i++) dvs_ff[i] <= dvs_ff[i-1];
         for (int i = 8; i <= 10; i++) lhs_ff[i] <= lhs_ff[i-1];
         for (int i = 12; i <= NSTG; i++) hx_ff[i] <= hx_ff[i-1];
         v1p5_ff[7] <= v1p5_ff[6];
         v1p2_ff[7] <= v1p2_ff[6];
         // temperature
         ta_ff    <= (rt32 >>> 3) - (t1 <<< 1);
         td_ff    <= (rt32 >>> 4) - t1;
         am_ff    <= ta_ff * t2;
         dd_ff    <= td_ff * td_ff;
         a1_ff    <= am_ff >>> 11;
         d3_ff    <= (dd_ff >>> 12) * t3;
         tf_ff[4] <= a1_ff + (d3_ff >>> 14);
         tcm_ff   <= tf_ff[4] * 32'sd5 + 32'sd128;
         tc_ff[6] <= tcm_ff >>> 8;
         // pressure up to the divide
         v1_ff      <= 33'(tf_ff[4]) - 33'sd128000;
         v1sq_ff    <= {32'b0, va} * {32'b0, va};
         v1p5_ff[6] <= v1_ff * p5;
         v1p2_ff[6] <= v1_ff * p2;
         v2a_ff     <= $signed(v1sq_ff) * p6;
         v1a_ff     <= $signed(v1sq_ff) * p3;
         v2_ff      <= v2a_ff + (v1p5_ff[7] <<< 17) + (64'(p4) <<< 35);
         v1b_ff     <= (v1a_ff >>> 8) + (v1p2_ff[7] <<< 12);
         v1c_ff     <= (64'sh0000_8000_0000_0000 + v1b_ff) * p1;
         num_ff[9]  <= ((64'(pr) << 31) - v2_ff) * 64'd3125;
         dvs_ff[10] <= dvw[31:0];
         // humidity
         hx6_ff     <= xw * h6;
         hx3_ff     <= xw * h3;
         h5x_ff     <= h5 * xw;
         lhsp_ff    <= (rh32 <<< 14) - (h4 <<< 20) - h5x_ff + 32'sd16384;
         ha_ff      <= hx6_ff >>> 10;
         hb_ff      <= (hx3_ff >>> 11) + 32'sd32768;
         lhs_ff[7]  <= lhsp_ff >>> 15;
         inm_ff     <= ha_ff * hb_ff;
         inner_ff   <= (inm_ff >>> 10) + 32'sd2097152;
         rhsm_ff    <= inner_ff * h2;
         rhs_ff     <= (rhsm_ff + 32'sd8192) >>> 14;
         hx_ff[11]  <= lhs_ff[10] * rhs_ff;
         qq_ff      <= qw * qw;
         hs_ff      <= (qq_ff >>> 7) * h1;
      end
   end

   always_comb begin
      q_item.fine_t = tf_ff[NSTG];
      q_item.temp_c = tc_ff[NSTG];
      q_item.num    = num_ff[NSTG];
      q_item.dvs    = dvs_ff[NSTG];
      if (hf[31]) begin
         q_item.hum = '0;
      end else if (hf > 32'sd419430400) begin
         q_item.hum = 17'd102400;
      end else begin
         q_item.hum = hf[28:12];
      end
   end

endmodule
`default_nettype wire

/* rtl/esc_fifo.sv */
`default_nettype none
`include "env_sensor_compensation_defines.svh"
module esc_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  esc_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output esc_pkg::item_type pop_item,
   output logic              not_empty
);
   import esc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   cnt_ff;

   assign full      = cnt_ff == CNT_W'(DEPTH);
   assign not_empty = cnt_ff != '0;
   assign pop_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ESC_ASSERT_NXT(a_cnt_up, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1)
   `ESC_ASSERT_NXT(a_cnt_down, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 1'b1)
   `ESC_ASSERT_IMP(a_cnt_max, clock, reset, 1'b1, cnt_ff <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

/* rtl/esc_back.sv */
`default_nettype none
module esc_back (
   input  logic               clock,
   input  logic               reset,
   input  esc_pkg::calib_type calib,
   input  logic               q_valid,
   input  esc_pkg::item_type  q_item,
   output logic               q_pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [31:0]        fine_temperature,
   output logic [31:0]        temperature_centi,
   output logic [31:0]        pressure_q24_8,
   output logic               pressure_invalid,
   output logic [16:0]        humidity_q22_10
);
   import esc_pkg::*;

   localparam int unsigned QBITS = 64;

   typedef struct packed {
      logic [31:0] rem;
      logic [63:0] n;
      logic [31:0] ud;
      logic        neg;
      logic        bad;
      logic [31:0] fine_t;
      logic [31:0] temp_c;
      logic [16:0] hum;
   } div_type;

   typedef struct packed {
      logic        bad;
      logic [31:0] fine_t;
      logic [31:0] temp_c;
      logic [16:0] hum;
   } info_type;

   // restoring divide, one quotient bit per stage
   function automatic div_type div_step(div_type d);
      logic [32:0] trial;
      div_type     r;
      trial = {d.rem, d.n[QBITS-1]};
      r     = d;
      if (trial >= {1'b0, d.ud}) begin
         r.rem = 32'(trial - {1'b0, d.ud});
         r.n   = {d.n[QBITS-2:0], 1'b1};
      end else begin
         r.rem = trial[31:0];
         r.n   = {d.n[QBITS-2:0], 1'b0};
      end
      return r;
   endfunction

   logic signed [15:0] p7, p8, p9;
   assign p7 = $signed(calib.press_c[15:0]);
   assign p8 = $signed(calib.press_c[31:16]);
   assign p9 = $signed(calib.press_c[47:32]);

   logic               en;
   logic [QBITS:0]     dv_ff;
   div_type            d_ff [0:QBITS];
   logic [4:1]         pv_ff;
   info_type           inf_ff [1:4];
   logic signed [63:0] p_ff [1:4];
   logic signed [63:0] pp8_ff [2:4];
   logic [63:0]        m0_ff, ss_ff;
   logic [31:0]        m1_ff;
   logic signed [63:0] ss9_ff;
   logic               out_vld_ff;
   info_type           out_inf_ff;
   logic [31:0]        out_pres_ff;

   logic signed [63:0] sw, psum, pres;

   assign en    = !out_vld_ff || out_ready;
   assign q_pop = en && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff      <= '0;
         pv_ff      <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         dv_ff      <= {dv_ff[QBITS-1:0], q_valid};
         pv_ff      <= {pv_ff[3:1], dv_ff[QBITS]};
         out_vld_ff <= pv_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0].rem    <= '0;
         d_ff[0].n      <= q_item.num[63] ? -q_item.num : q_item.num;
         d_ff[0].ud     <= q_item.dvs[31] ? -q_item.dvs : q_item.dvs;
         d_ff[0].neg    <= q_item.num[63] ^ q_item.dvs[31];
         d_ff[0].bad    <= q_item.dvs == '0;
         d_ff[0].fine_t <= q_item.fine_t;
         d_ff[0].temp_c <= q_item.temp_c;
         d_ff[0].hum    <= q_item.hum;
         for (int i = 1; i <= QBITS; i++) d_ff[i] <= div_step(d_ff[i-1]);
      end
   end

   assign sw   = p_ff[1] >>> 13;
   assign psum = p_ff[4] + (ss9_ff >>> 25) + (pp8_ff[4] >>> 19);
   assign pres = (psum >>> 8) + (64'(p7) <<< 4);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[1]          <= d_ff[QBITS].neg ? $signed(-d_ff[QBITS].n) : $signed(d_ff[QBITS].n);
         inf_ff[1].bad    <= d_ff[QBITS].bad;
         inf_ff[1].fine_t <= d_ff[QBITS].fine_t;
         inf_ff[1].temp_c <= d_ff[QBITS].temp_c;
         inf_ff[1].hum    <= d_ff[QBITS].hum;
         for (int i = 2; i <= 4; i++) begin
            p_ff[i]   <= p_ff[i-1];
            inf_ff[i] <= inf_ff[i-1];
         end
         pp8_ff[2]   <= p_ff[1] * p8;
         pp8_ff[3]   <= pp8_ff[2];
         pp8_ff[4]   <= pp8_ff[3];
         // low 64 bits of s*s from 32-bit halves
         m0_ff       <= {32'b0, sw[31:0]} * {32'b0, sw[31:0]};
         m1_ff       <= sw[31:0] * sw[63:32];
         ss_ff       <= m0_ff + {m1_ff[30:0], 33'b0};
         ss9_ff      <= $signed(ss_ff) * p9;
         out_inf_ff  <= inf_ff[4];
         out_pres_ff <= inf_ff[4].bad ? '0 : pres[31:0];
      end
   end

   assign out_valid         = out_vld_ff;
   assign fine_temperature  = out_inf_ff.fine_t;
   assign temperature_centi = out_inf_ff.temp_c;
   assign pressure_q24_8    = out_pres_ff;
   assign pressure_invalid  = out_inf_ff.bad;
   assign humidity_q22_10   = out_inf_ff.hum;

endmodule
`default_nettype wire

/* rtl/env_sensor_compensation.sv */
`default_nettype none
// Integer compensation of raw temperature, pressure and humidity readings.
// req_*: one request carries a raw reading set; accepted when req_tvalid
//   and req_tready are both high.
// rsp_*: one result per request, in request order; rsp_tuser flags a zero
//   pressure divisor, in which case the pressure field is zero.
// csr_*: calibration words, written one per cycle while csr_we is high;
//   write them only while no request is in flight.
// Throughput: one request per cycle while req_tready is high. The pipeline
//   is made of 13 front stages (the first loads at acceptance), the
//   request queue and a 70-stage back end whose 64-bit divide retires
//   one quotient bit per stage.
// When rsp_tvalid is high and rsp_tready low the back end holds; the front
//   end keeps taking requests until the queue is full and its last stage holds a request, then drops req_tready.
// Synchronous reset empties the pipeline and queue and clears all
//   calibration words to zero.
module env_sensor_compensation #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [47:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,   // raw_temperature, raw_pressure, raw_humidity
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // fine_temperature, temperature_centi,
                                     // pressure_q24_8, humidity_q22_10, zero pad
   output logic [0:0]   rsp_tuser    // pressure_invalid
);
   import esc_pkg::*;

   calib_type calib_ff;
   logic      q_full, q_push, q_pop, q_valid;
   item_type  push_item, pop_item;
   logic [31:0] fine_t, temp_c, pres;
   logic        bad;
   logic [16:0] hum;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_TEMP:    calib_ff.temp    <= csr_wdata;
            REG_PRESS_A: calib_ff.press_a <= csr_wdata;
            REG_PRESS_B: calib_ff.press_b <= csr_wdata;
            REG_PRESS_C: calib_ff.press_c <= csr_wdata;
            REG_HUM_A:   calib_ff.hum_a   <= csr_wdata[39:0];
            REG_HUM_B:   calib_ff.hum_b   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   esc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .calib           (calib_ff),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .raw_temperature (req_tdata[19:0]),
      .raw_pressure    (req_tdata[39:20]),
      .raw_humidity    (req_tdata[55:40]),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   esc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .not_empty (q_valid)
   );

   esc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .calib             (calib_ff),
      .q_valid           (q_valid),
      .q_item            (pop_item),
      .q_pop             (q_pop),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .fine_temperature  (fine_t),
      .temperature_centi (temp_c),
      .pressure_q24_8    (pres),
      .pressure_invalid  (bad),
      .humidity_q22_10   (hum)
   );

   assign rsp_tdata = {7'b0, hum, pres, temp_c, fine_t};
   assign rsp_tuser = bad;

endmodule
`default_nettype wire

/* verif/env_sensor_compensation_test.sv */
`timescale 1ns / 1ps
`default_nettype none
module env_sensor_compensation_test;
   import esc_pkg::*;

   localparam logic [2:0] REG_SPARE_6 = 3'd6;
   localparam logic [2:0] REG_SPARE_7 = 3'd7;
   localparam logic [31:0] HUM_CEILING = 32'd419430400;

   typedef struct packed {
      logic [15:0] rh;
      logic [19:0] rp;
      logic [19:0] rt;
   } reading_type;

   typedef struct packed {
      logic [31:0] fine_t;
      logic [31:0] temp_c;
      logic [31:0] press;
      logic        press_bad;
      logic [16:0] hum;
   } reading_out_type;

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [47:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [55:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [119:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   bit [47:0]       calib_shadow [0:5];
   reading_type     pending_reqs [$];
   reading_out_type expected_rsps [$];
   int              errors = 0;
   bit              sender_pause;
   bit              long_hold_req;
   bit              long_hold_done;
   int              hold_cnt;
   int              gap_left;
   int              burst_left;
   int              stall_mode;
   int              stall_mode_left;

   env_sensor_compensation dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   function automatic bit [31:0] asr32(bit [31:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic bit [63:0] asr64(bit [63:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic bit [63:0] sx64(bit [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic bit [63:0] signed_quotient(bit [63:0] num, bit [63:0] den);
      bit [63:0] un;
      bit [63:0] ud;
      bit [63:0] q;
      un = num[63] ? -num : num;
      ud = den[63] ? -den : den;
      q = un / ud;
      return (num[63] != den[63]) ? -q : q;
   endfunction

   function automatic reading_out_type compensate(reading_type r);
      reading_out_type o;
      bit [47:0] ct;
      bit [47:0] pa;
      bit [47:0] pb;
      bit [47:0] pc;
      bit [47:0] ha;
      bit [47:0] hb;
      bit [31:0] t1, t2, t3, a1, d, a2, tf, rt;
      bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, s, pres;
      bit [31:0] h1, h2, h3, h4, h5, h6, x, lhs, inner, rhs, q;
      ct = calib_shadow[REG_TEMP];
      pa = calib_shadow[REG_PRESS_A];
      pb = calib_shadow[REG_PRESS_B];
      pc = calib_shadow[REG_PRESS_C];
      ha = calib_shadow[REG_HUM_A];
      hb = calib_shadow[REG_HUM_B];
      rt = {12'b0, r.rt};

      t1 = {16'b0, ct[15:0]};
      t2 = {{16{ct[31]}}, ct[31:16]};
      t3 = {{16{ct[47]}}, ct[47:32]};
      a1 = asr32(((rt >> 3) - (t1 << 1)) * t2, 11);
      d = (rt >> 4) - t1;
      a2 = asr32(asr32(d * d, 12) * t3, 14);
      tf = a1 + a2;
      o.fine_t = tf;
      o.temp_c = asr32(tf * 32'd5 + 32'd128, 8);

      p1 = {48'b0, pa[15:0]};
      p2 = sx64(pa[31:16]);
      p3 = sx64(pa[47:32]);
      p4 = sx64(pb[15:0]);
      p5 = sx64(pb[31:16]);
      p6 = sx64(pb[47:32]);
      p7 = sx64(pc[15:0]);
      p8 = sx64(pc[31:16]);
      p9 = sx64(pc[47:32]);
      v1 = {{32{tf[31]}}, tf} - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
      pres = 64'd0;
      o.press_bad = 1'b1;
      if (v1 != 64'd0) begin
         p = 64'd1048576 - {44'b0, r.rp};
         p = signed_quotient(((p << 31) - v2) * 64'd3125, v1);
         s = asr64(p, 13);
         v1 = asr64(p9 * s * s, 25);
         v2 = asr64(p8 * p, 19);
         pres = asr64(p + v1 + v2, 8) + (p7 << 4);
         o.press_bad = 1'b0;
      end
      o.press = pres[31:0];

      h1 = {24'b0, ha[7:0]};
      h2 = {{16{ha[23]}}, ha[23:8]};
      h3 = {24'b0, ha[31:24]};
      h6 = {{24{ha[39]}}, ha[39:32]};
      h4 = {{16{hb[15]}}, hb[15:0]};
      h5 = {{16{hb[31]}}, hb[31:16]};
      x = tf - 32'd76800;
      lhs = asr32(({16'b0, r.rh} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
      inner = asr32(asr32(x * h6, 10) * (asr32(x * h3, 11) + 32'd32768), 10) + 32'd2097152;
      rhs = asr32(inner * h2 + 32'd8192, 14);
      x = lhs * rhs;
      q = asr32(x, 15);
      x = x - asr32(asr32(q * q, 7) * h1, 4);
      if (x[31])
         x = 32'd0;
      else if (x > HUM_CEILING)
         x = HUM_CEILING;
      o.hum = x[28:12];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // sender: bursts and gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         gap_left <= 0;
         burst_left <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsps.push_back(compensate(reading_type'(req_tdata)));
         if (!(req_tvalid && !req_tready)) begin
            if (sender_pause || gap_left > 0 || pending_reqs.size() == 0) begin
               req_tvalid <= 1'b0;
               if (gap_left > 0)
                  gap_left <= gap_left - 1;
            end else begin
               req_tdata <= pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
         long_hold_done <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         hold_cnt <= 600;
         long_hold_done <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end
   end

   // receiver: stall pattern and result checking
   always @(posedge clock) begin
      reading_out_type want;
      logic [31:0] got_fine;
      logic [31:0] got_tc;
      logic [31:0] got_press;
      logic [16:0] got_hum;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_mode <= 0;
         stall_mode_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_fine = rsp_tdata[31:0];
            got_tc = rsp_tdata[63:32];
            got_press = rsp_tdata[95:64];
            got_hum = rsp_tdata[112:96];
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[63:0], 64'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (got_fine !== want.fine_t)
                  report_mismatch("fine_temperature", 64'(got_fine), 64'(want.fine_t));
               if (got_tc !== want.temp_c)
                  report_mismatch("temperature_centi", 64'(got_tc), 64'(want.temp_c));
               if (got_press !== want.press)
                  report_mismatch("pressure_q24_8", 64'(got_press), 64'(want.press));
               if (rsp_tuser[0] !== want.press_bad)
                  report_mismatch("pressure_invalid", 64'(rsp_tuser[0]),
                                  64'(want.press_bad));
               if (got_hum !== want.hum)
                  report_mismatch("humidity_q22_10", 64'(got_hum), 64'(want.hum));
            end
         end
         if (stall_mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_mode_left <= $urandom_range(20, 120);
         end else begin
            stall_mode_left <= stall_mode_left - 1;
         end
         if (hold_cnt > 0)
            rsp_tready <= 1'b0;
         else if (stall_mode == 1)
            rsp_tready <= ($urandom_range(0, 9) > 3);
         else if (stall_mode == 2)
            rsp_tready <= (stall_mode_left % 3 != 0);
         else
            rsp_tready <= 1'b1;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_calib(logic [2:0] idx, logic [47:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_TEMP, REG_PRESS_A, REG_PRESS_B, REG_PRESS_C: calib_shadow[idx] = val;
         REG_HUM_A: calib_shadow[idx] = {8'b0, val[39:0]};
         REG_HUM_B: calib_shadow[idx] = {16'b0, val[31:0]};
         default: ;
      endcase
   endtask

   task automatic load_calib(logic [47:0] t, logic [47:0] pa, logic [47:0] pb,
                             logic [47:0] pc, logic [47:0] ha, logic [47:0] hb);
      write_calib(REG_TEMP, t);
      write_calib(REG_PRESS_A, pa);
      write_calib(REG_PRESS_B, pb);
      write_calib(REG_PRESS_C, pc);
      write_calib(REG_HUM_A, ha);
      write_calib(REG_HUM_B, hb);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic reading_type rand_reading();
      reading_type r;
      r.rt = 20'($urandom);
      r.rp = 20'($urandom);
      r.rh = 16'($urandom);
      case ($urandom_range(0, 9))
         0: r.rt = ($urandom_range(0, 1) == 0) ? 20'h0 : 20'hFFFFF;
         1: r.rp = ($urandom_range(0, 1) == 0) ? 20'h0 : 20'hFFFFF;
         2: r.rh = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'hFFFF;
         3, 4, 5, 6: begin
            r.rt = 20'($urandom_range(380000, 620000));
            r.rp = 20'($urandom_range(200000, 500000));
            r.rh = 16'($urandom_range(15000, 40000));
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_directed();
      reading_type r;
      r = '{rh: 16'h0, rp: 20'h0, rt: 20'h0};             pending_reqs.push_back(r);
      r = '{rh: 16'hFFFF, rp: 20'hFFFFF, rt: 20'hFFFFF}; pending_reqs.push_back(r);
      r = '{rh: 16'hFFFF, rp: 20'h0, rt: 20'h0};         pending_reqs.push_back(r);
      r = '{rh: 16'h0, rp: 20'hFFFFF, rt: 20'h0};        pending_reqs.push_back(r);
      r = '{rh: 16'h0, rp: 20'h0, rt: 20'hFFFFF};        pending_reqs.push_back(r);
      r = '{rh: 16'h6A5C, rp: 20'd415148, rt: 20'd519888}; pending_reqs.push_back(r);
      r = '{rh: 16'h8000, rp: 20'h80000, rt: 20'h80000}; pending_reqs.push_back(r);
      r = '{rh: 16'h5555, rp: 20'hAAAAA, rt: 20'h55555}; pending_reqs.push_back(r);
   endtask

   task automatic queue_random(int n);
      repeat (n) pending_reqs.push_back(rand_reading());
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      sender_pause = 1'b0;
      long_hold_req = 1'b0;
      for (int i = 0; i < 6; i++) calib_shadow[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // calibration left at reset: zero divisor path
      queue_directed();
      queue_random(40);
      wait_drained();

      // typical calibration, with a long receiver hold-off
      load_calib({16'hFC18, 16'd26435, 16'd27504},
                 {16'd3024, 16'hD643, 16'd36477},
                 {16'hFFF9, 16'd140, 16'd2855},
                 {16'd6000, 16'hC6F8, 16'd15500},
                 {8'hFF, 8'd30, 8'd0, 16'd362, 8'd75},
                 {16'h0, 16'd50, 16'd313});
      queue_directed();
      long_hold_req = 1'b1;
      queue_random(600);
      while (pending_reqs.size() > 300) @(posedge clock);
      sender_pause = 1'b1;
      while (expected_rsps.size() != 0) @(posedge clock);
      sender_pause = 1'b0;
      wait_drained();

      // all ones, then spare indexes that must be ignored
      load_calib({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
      write_calib(REG_SPARE_6, rand48());
      write_calib(REG_SPARE_7, rand48());
      @(posedge clock);
      csr_we <= 1'b0;
      queue_directed();
      queue_random(60);
      wait_drained();

      // most negative signed fields, largest unsigned ones
      load_calib({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
                 {3{16'h8000}}, {3{16'h8000}},
                 {8'h80, 8'hFF, 16'h8000, 8'hFF}, {16'h8000, 16'h8000});
      queue_directed();
      queue_random(60);
      wait_drained();

      // largest positive signed fields, unsigned ones at zero or one
      load_calib({16'h7FFF, 16'h7FFF, 16'h0001}, {16'h7FFF, 16'h7FFF, 16'h0001},
                 {3{16'h7FFF}}, {3{16'h7FFF}},
                 {8'h7F, 8'h00, 16'h7FFF, 8'h00}, {16'h7FFF, 16'h7FFF});
      queue_directed();
      queue_random(60);
      wait_drained();

      // random calibration sets
      for (int ph = 0; ph < 5; ph++) begin
         load_calib(rand48(), (ph == 2) ? (rand48() & 48'hFFFF_FFFF_0000) : rand48(),
                    rand48(), rand48(), rand48(), rand48());
         queue_random(200);
         wait_drained();
      end

      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("env_sensor_compensation_test: done, clean");
      else
         $display("env_sensor_compensation_test: done, errors");
      $finish;
   end

   initial begin
      #6000000;
      $display("env_sensor_compensation_test: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
